// ===== hw/rtl/quaternion_vector_rotate_core_macros.svh =====
// Assertion macros shared by the quaternion rotation core.
`ifndef QUATERNION_VECTOR_ROTATE_CORE_MACROS_SVH
`define QUATERNION_VECTOR_ROTATE_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define QVR_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define QVR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/qvr_pkg.sv =====
// Shared types and constants of the quaternion rotation core.
package qvr_pkg;

    // Default component width of quaternion and vector.
    localparam int COMPONENT_BITS_DEF = 16;

    // Sideband that travels with each beat through the pipeline.
    typedef struct packed {
        logic       valid;
        logic       err;
        logic [2:0] neg;
    } qvr_ctl_t;

endpackage

// ===== hw/rtl/quaternion_vector_rotate_core.sv =====
// Throughput: one beat per cycle; every stage advances unless a held result is stalled.
// The depth is set by the bit-per-stage rounding divider, one stage per quotient bit.
// Reset (rst_n low, asynchronous) clears all valid bits; payload registers are not reset.
// A zero quaternion gives zero_quat_error with a zero rotated vector.
module quaternion_vector_rotate_core #(
    parameter int COMPONENT_BITS = qvr_pkg::COMPONENT_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          quat_stall,
    input  logic signed [COMPONENT_BITS-1:0] quat_w,
    input  logic signed [COMPONENT_BITS-1:0] quat_x,
    input  logic signed [COMPONENT_BITS-1:0] quat_y,
    input  logic signed [COMPONENT_BITS-1:0] quat_z,
    input  logic signed [COMPONENT_BITS-1:0] vec_x,
    input  logic signed [COMPONENT_BITS-1:0] vec_y,
    input  logic signed [COMPONENT_BITS-1:0] vec_z,
    input  logic                          inverse,
    output logic                          rot_valid,
    input  logic                          rot_stall,
    output logic signed [COMPONENT_BITS:0] rotated_x,
    output logic signed [COMPONENT_BITS:0] rotated_y,
    output logic signed [COMPONENT_BITS:0] rotated_z,
    output logic                          zero_quat_error
);
    import qvr_pkg::*;

    localparam int CB = COMPONENT_BITS;
    localparam int QB = CB + 1;
    localparam int RW = 2 * CB + 3;
    localparam int DW = 3 * CB + 5;
    localparam int VW = 2 * CB + 2;

    logic                 en;
    qvr_ctl_t             mat_ctl;
    logic [2*CB:0]        mat_norm;
    logic signed [VW-1:0] mat_m [9];
    logic signed [CB-1:0] mat_v [3];

    qvr_ctl_t             st_ctl [QB+1];
    logic [DW-1:0]        st_dvd [QB+1][3];
    logic [VW-1:0]        st_dvs [QB+1];
    logic [RW-1:0]        st_rem [QB+1][3];
    logic [QB-1:0]        st_quo [QB+1][3];

    logic                 out_valid_reg;
    logic                 out_err_reg;
    logic [QB-1:0]        out_reg [3];
    logic [QB-1:0]        out_next [3];

    // The whole pipe moves unless a finished result is held.
    assign en         = !(out_valid_reg && rot_stall);
    assign quat_stall = !en;

    qvr_matrix #(.CB(CB)) u_matrix (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (in_valid),
        .quat_w   (quat_w),
        .quat_x   (quat_x),
        .quat_y   (quat_y),
        .quat_z   (quat_z),
        .vec_x    (vec_x),
        .vec_y    (vec_y),
        .vec_z    (vec_z),
        .inverse  (inverse),
        .ctl_out  (mat_ctl),
        .norm_out (mat_norm),
        .mat_out  (mat_m),
        .vec_out  (mat_v)
    );

    qvr_mac #(.CB(CB)) u_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .ctl_in  (mat_ctl),
        .norm_in (mat_norm),
        .mat_in  (mat_m),
        .vec_in  (mat_v),
        .ctl_out (st_ctl[0]),
        .dvd_out (st_dvd[0]),
        .dvs_out (st_dvs[0])
    );

    // Partial remainder starts from the dividend bits above the quotient.
    for (genvar i = 0; i < 3; i++)
    begin : g_seed
        assign st_rem[0][i] = st_dvd[0][i][QB +: RW];
        assign st_quo[0][i] = '0;
    end

    // One divider stage per quotient bit.
    for (genvar s = 0; s < QB; s++)
    begin : g_div
        qvr_div_stage #(.CB(CB), .STEP(s)) u_stage (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .ctl_in  (st_ctl[s]),
            .dvd_in  (st_dvd[s]),
            .dvs_in  (st_dvs[s]),
            .rem_in  (st_rem[s]),
            .quo_in  (st_quo[s]),
            .ctl_out (st_ctl[s+1]),
            .dvd_out (st_dvd[s+1]),
            .dvs_out (st_dvs[s+1]),
            .rem_out (st_rem[s+1]),
            .quo_out (st_quo[s+1])
        );
    end

    // Restore sign, force zero on a zero quaternion.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            if (st_ctl[QB].err)
            begin
                out_next[i] = '0;
            end
            else if (st_ctl[QB].neg[i])
            begin
                out_next[i] = -st_quo[QB][i];
            end
            else
            begin
                out_next[i] = st_quo[QB][i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= st_ctl[QB].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg     <= out_next;
            out_err_reg <= st_ctl[QB].err;
        end
    end

    assign rot_valid       = out_valid_reg;
    assign rotated_x       = out_reg[0];
    assign rotated_y       = out_reg[1];
    assign rotated_z       = out_reg[2];
    assign zero_quat_error = out_err_reg;

`include "quaternion_vector_rotate_core_macros.svh"

    `QVR_ASSERT_IMPL(a_err_zero, clk, rst_n, rot_valid && zero_quat_error,
        (rotated_x == '0) && (rotated_y == '0) && (rotated_z == '0),
        "zero quaternion must give a zero vector")
    `QVR_ASSERT_IMPL(a_stall_link, clk, rst_n, 1'b1, quat_stall == (rot_valid && rot_stall),
        "input stall must follow a held result")
    `QVR_ASSERT_NEXT(a_hold_tail, clk, rst_n, rot_valid && rot_stall,
        rot_valid && $stable(st_ctl[QB]), "pipeline tail moved while held")

endmodule

// ===== hw/rtl/qvr_matrix.sv =====
// Conjugation, quadratic terms and rotation matrix stages.
module qvr_matrix #(
    parameter int CB = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   in_valid,
    input  logic signed [CB-1:0]   quat_w,
    input  logic signed [CB-1:0]   quat_x,
    input  logic signed [CB-1:0]   quat_y,
    input  logic signed [CB-1:0]   quat_z,
    input  logic signed [CB-1:0]   vec_x,
    input  logic signed [CB-1:0]   vec_y,
    input  logic signed [CB-1:0]   vec_z,
    input  logic                   inverse,
    output qvr_pkg::qvr_ctl_t      ctl_out,
    output logic [2*CB:0]          norm_out,
    output logic signed [2*CB+1:0] mat_out [9],
    output logic signed [CB-1:0]   vec_out [3]
);
    import qvr_pkg::*;

    localparam int EW = CB + 1;
    localparam int PW = 2 * CB + 2;
    localparam int SW = PW + 2;
    localparam int NW = 2 * CB + 1;

    // Stage 1: conjugated components.
    logic signed [EW-1:0] w_reg, x_reg, y_reg, z_reg;
    logic signed [EW-1:0] w_next, x_next, y_next, z_next;
    logic signed [CB-1:0] v1_reg [3];
    qvr_ctl_t             c1_reg, c1_next;

    // Stage 2: the ten quadratic products.
    logic signed [PW-1:0] pr_reg [10];
    logic signed [PW-1:0] pr_next [10];
    logic signed [CB-1:0] v2_reg [3];
    qvr_ctl_t             c2_reg;

    // Stage 3: matrix and squared norm.
    logic signed [PW-1:0] m_reg [9];
    logic signed [PW-1:0] m_next [9];
    logic [NW-1:0]        n_reg, n_next;
    logic signed [CB-1:0] v3_reg [3];
    qvr_ctl_t             c3_reg;

    logic signed [SW-1:0] ww, xx, yy, zz, xy, wz, xz, wy, yz, wx;

    // Conjugate on inverse; the extra bit keeps the most negative value exact.
    always_comb
    begin
        w_next = EW'(quat_w);
        x_next = inverse ? -EW'(quat_x) : EW'(quat_x);
        y_next = inverse ? -EW'(quat_y) : EW'(quat_y);
        z_next = inverse ? -EW'(quat_z) : EW'(quat_z);
        c1_next       = '0;
        c1_next.valid = in_valid;
        c1_next.err   = (quat_w == '0) && (quat_x == '0) && (quat_y == '0) && (quat_z == '0);
    end

    // Products, one multiplier each.
    always_comb
    begin
        pr_next[0] = PW'(w_reg * w_reg);
        pr_next[1] = PW'(x_reg * x_reg);
        pr_next[2] = PW'(y_reg * y_reg);
        pr_next[3] = PW'(z_reg * z_reg);
        pr_next[4] = PW'(x_reg * y_reg);
        pr_next[5] = PW'(w_reg * z_reg);
        pr_next[6] = PW'(x_reg * z_reg);
        pr_next[7] = PW'(w_reg * y_reg);
        pr_next[8] = PW'(y_reg * z_reg);
        pr_next[9] = PW'(w_reg * x_reg);
    end

    // Matrix of unnormalized quadratic forms; cross terms doubled.
    always_comb
    begin
        ww = SW'(pr_reg[0]);
        xx = SW'(pr_reg[1]);
        yy = SW'(pr_reg[2]);
        zz = SW'(pr_reg[3]);
        xy = SW'(pr_reg[4]);
        wz = SW'(pr_reg[5]);
        xz = SW'(pr_reg[6]);
        wy = SW'(pr_reg[7]);
        yz = SW'(pr_reg[8]);
        wx = SW'(pr_reg[9]);
        n_next    = NW'(ww + xx + yy + zz);
        m_next[0] = PW'(ww + xx - yy - zz);
        m_next[1] = PW'((xy - wz) <<< 1);
        m_next[2] = PW'((xz + wy) <<< 1);
        m_next[3] = PW'((xy + wz) <<< 1);
        m_next[4] = PW'(ww + yy - xx - zz);
        m_next[5] = PW'((yz - wx) <<< 1);
        m_next[6] = PW'((xz - wy) <<< 1);
        m_next[7] = PW'((yz + wx) <<< 1);
        m_next[8] = PW'(ww + zz - xx - yy);
    end

    // Valid bits of the three stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_reg <= '0;
            c2_reg <= '0;
            c3_reg <= '0;
        end
        else if (en)
        begin
            c1_reg <= c1_next;
            c2_reg <= c1_reg;
            c3_reg <= c2_reg;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            w_reg     <= w_next;
            x_reg     <= x_next;
            y_reg     <= y_next;
            z_reg     <= z_next;
            v1_reg[0] <= vec_x;
            v1_reg[1] <= vec_y;
            v1_reg[2] <= vec_z;
            pr_reg    <= pr_next;
            v2_reg    <= v1_reg;
            m_reg     <= m_next;
            n_reg     <= n_next;
            v3_reg    <= v2_reg;
        end
    end

    assign ctl_out  = c3_reg;
    assign norm_out = n_reg;
    assign mat_out  = m_reg;
    assign vec_out  = v3_reg;

endmodule

// ===== hw/rtl/qvr_mac.sv =====
// Matrix-vector product and rounding-divide operand stages.
module qvr_mac #(
    parameter int CB = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  qvr_pkg::qvr_ctl_t      ctl_in,
    input  logic [2*CB:0]          norm_in,
    input  logic signed [2*CB+1:0] mat_in [9],
    input  logic signed [CB-1:0]   vec_in [3],
    output qvr_pkg::qvr_ctl_t      ctl_out,
    output logic [3*CB+4:0]        dvd_out [3],
    output logic [2*CB+1:0]        dvs_out
);
    import qvr_pkg::*;

    localparam int MW  = 2 * CB + 2;
    localparam int PMW = MW + CB;
    localparam int AW  = PMW + 2;
    localparam int DW  = AW + 1;
    localparam int NW  = 2 * CB + 1;
    localparam int VW  = NW + 1;

    // Stage 4: the nine matrix-vector products.
    logic signed [PMW-1:0] p_reg [9];
    logic signed [PMW-1:0] p_next [9];
    logic [NW-1:0]         n4_reg;
    qvr_ctl_t              c4_reg;

    // Stage 5: dividend 2|acc|+n and divisor 2n.
    logic [DW-1:0]         d_reg [3];
    logic [DW-1:0]         d_next [3];
    logic [VW-1:0]         s_reg, s_next;
    qvr_ctl_t              c5_reg, c5_next;

    logic signed [AW-1:0]  acc [3];
    logic [AW-1:0]         mag [3];

    // Row i, column j of the matrix meets vector component j.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                p_next[3*i+j] = PMW'(mat_in[3*i+j] * vec_in[j]);
            end
        end
    end

    // Row sums, sign and magnitude.
    always_comb
    begin
        c5_next = c4_reg;
        for (int i = 0; i < 3; i++)
        begin
            acc[i] = AW'(p_reg[3*i]) + AW'(p_reg[3*i+1]) + AW'(p_reg[3*i+2]);
            c5_next.neg[i] = acc[i][AW-1];
            mag[i] = acc[i][AW-1] ? AW'(-acc[i]) : AW'(acc[i]);
            d_next[i] = {mag[i], 1'b0} + DW'(n4_reg);
        end
        s_next = {n4_reg, 1'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c4_reg <= '0;
            c5_reg <= '0;
        end
        else if (en)
        begin
            c4_reg <= ctl_in;
            c5_reg <= c5_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg  <= p_next;
            n4_reg <= norm_in;
            d_reg  <= d_next;
            s_reg  <= s_next;
        end
    end

    assign ctl_out = c5_reg;
    assign dvd_out = d_reg;
    assign dvs_out = s_reg;

endmodule

// ===== hw/rtl/qvr_div_stage.sv =====
// One restoring-division step for all three lanes.
module qvr_div_stage #(
    parameter int CB   = 16,
    parameter int STEP = 0
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  qvr_pkg::qvr_ctl_t ctl_in,
    input  logic [3*CB+4:0]   dvd_in [3],
    input  logic [2*CB+1:0]   dvs_in,
    input  logic [2*CB+2:0]   rem_in [3],
    input  logic [CB:0]       quo_in [3],
    output qvr_pkg::qvr_ctl_t ctl_out,
    output logic [3*CB+4:0]   dvd_out [3],
    output logic [2*CB+1:0]   dvs_out,
    output logic [2*CB+2:0]   rem_out [3],
    output logic [CB:0]       quo_out [3]
);
    import qvr_pkg::*;

    localparam int QB  = CB + 1;
    localparam int RW  = 2 * CB + 3;
    localparam int BIT = QB - 1 - STEP;

    logic [RW-1:0] rem_reg [3];
    logic [RW-1:0] rem_next [3];
    logic [QB-1:0] quo_reg [3];
    logic [QB-1:0] quo_next [3];
    logic [3*CB+4:0] dvd_reg [3];
    logic [2*CB+1:0] dvs_reg;
    qvr_ctl_t        ctl_reg;
    logic [RW-1:0]   trial [3];
    logic            fits [3];

    // Bring down one dividend bit and subtract where the divisor fits.
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            trial[i]    = {rem_in[i][RW-2:0], dvd_in[i][BIT]};
            fits[i]     = trial[i] >= RW'(dvs_in);
            rem_next[i] = fits[i] ? trial[i] - RW'(dvs_in) : trial[i];
            quo_next[i] = {quo_in[i][QB-2:0], fits[i]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
            dvd_reg <= dvd_in;
            dvs_reg <= dvs_in;
        end
    end

    assign ctl_out = ctl_reg;
    assign dvd_out = dvd_reg;
    assign dvs_out = dvs_reg;
    assign rem_out = rem_reg;
    assign quo_out = quo_reg;

endmodule

// ===== sim/tb_quaternion_vector_rotate_core.sv =====
// Self-checking testbench for the quaternion vector rotation core.
`timescale 1ns / 1ps

module tb_quaternion_vector_rotate_core;

    localparam int CB = qvr_pkg::COMPONENT_BITS_DEF;
    localparam int OB = CB + 1;
    localparam int LATENCY = CB + 7;

    typedef struct {
        logic signed [OB-1:0] rx;
        logic signed [OB-1:0] ry;
        logic signed [OB-1:0] rz;
        logic                 err;
    } rotation_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic quat_stall;
    logic signed [CB-1:0] quat_w = '0, quat_x = '0, quat_y = '0, quat_z = '0;
    logic signed [CB-1:0] vec_x = '0, vec_y = '0, vec_z = '0;
    logic inverse = 1'b0;
    logic rot_valid;
    logic rot_stall = 1'b0;
    logic signed [OB-1:0] rotated_x, rotated_y, rotated_z;
    logic zero_quat_error;

    rotation_t expected_rotations[$];
    int mismatch_count = 0;
    int orphan_count = 0;
    bit stall_enable = 1'b1;

    quaternion_vector_rotate_core dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .quat_stall(quat_stall),
        .quat_w(quat_w), .quat_x(quat_x), .quat_y(quat_y), .quat_z(quat_z),
        .vec_x(vec_x), .vec_y(vec_y), .vec_z(vec_z), .inverse(inverse),
        .rot_valid(rot_valid), .rot_stall(rot_stall),
        .rotated_x(rotated_x), .rotated_y(rotated_y), .rotated_z(rotated_z),
        .zero_quat_error(zero_quat_error)
    );

    always #6 clk = ~clk;

    // Rounded num/n, nearest with ties away from zero; n is positive.
    function automatic logic signed [OB-1:0] round_quotient(longint num, longint n);
        longint mag;
        longint q;
        begin
            mag = (num < 0) ? -num : num;
            q = (2 * mag + n) / (2 * n);
            return OB'((num < 0) ? -q : q);
        end
    endfunction

    // Rotate the vector by the normalized quaternion (or its conjugate).
    function automatic rotation_t rotate_vector(
        logic signed [CB-1:0] qw, logic signed [CB-1:0] qx,
        logic signed [CB-1:0] qy, logic signed [CB-1:0] qz,
        logic signed [CB-1:0] px, logic signed [CB-1:0] py,
        logic signed [CB-1:0] pz, logic inv);
        longint w, x, y, z, a, b, c, ww, xx, yy, zz, n;
        longint m00, m01, m02, m10, m11, m12, m20, m21, m22;
        rotation_t r;
        begin
            w = qw; x = qx; y = qy; z = qz; a = px; b = py; c = pz;
            if (inv)
            begin
                x = -x; y = -y; z = -z;
            end
            r.err = 1'b0;
            if (w == 0 && x == 0 && y == 0 && z == 0)
            begin
                r.rx = '0; r.ry = '0; r.rz = '0; r.err = 1'b1;
                return r;
            end
            ww = w * w; xx = x * x; yy = y * y; zz = z * z;
            n = ww + xx + yy + zz;
            m00 = ww + xx - yy - zz;
            m01 = 2 * (x * y - w * z);
            m02 = 2 * (x * z + w * y);
            m10 = 2 * (x * y + w * z);
            m11 = ww + yy - xx - zz;
            m12 = 2 * (y * z - w * x);
            m20 = 2 * (x * z - w * y);
            m21 = 2 * (y * z + w * x);
            m22 = ww + zz - xx - yy;
            // Products reach about 2^47; sums stay well inside 64 bits.
            r.rx = round_quotient(m00 * a + m01 * b + m02 * c, n);
            r.ry = round_quotient(m10 * a + m11 * b + m12 * c, n);
            r.rz = round_quotient(m20 * a + m21 * b + m22 * c, n);
            return r;
        end
    endfunction

    // Random gap: mostly short, occasionally long.
    function automatic int pick_gap();
        int sel;
        begin
            sel = $urandom_range(0, 99);
            if (sel < 55) return 0;
            if (sel < 92) return $urandom_range(1, 3);
            return $urandom_range(10, 40);
        end
    endfunction

    function automatic logic signed [CB-1:0] pick_component();
        int sel;
        begin
            sel = $urandom_range(0, 9);
            case (sel)
                0: return {1'b1, {(CB-1){1'b0}}};
                1: return {1'b0, {(CB-1){1'b1}}};
                2: return CB'(int'($urandom_range(0, 6)) - 3);
                default: return CB'($urandom);
            endcase
        end
    endfunction

    // Send one beat and record its expected rotation.
    task automatic send_beat(logic signed [CB-1:0] qw, logic signed [CB-1:0] qx,
                             logic signed [CB-1:0] qy, logic signed [CB-1:0] qz,
                             logic signed [CB-1:0] px, logic signed [CB-1:0] py,
                             logic signed [CB-1:0] pz, logic inv, int gap);
        begin
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            in_valid <= 1'b1;
            quat_w <= qw; quat_x <= qx; quat_y <= qy; quat_z <= qz;
            vec_x <= px; vec_y <= py; vec_z <= pz; inverse <= inv;
            expected_rotations.push_back(rotate_vector(qw, qx, qy, qz, px, py, pz, inv));
            @(posedge clk);
            while (quat_stall) @(posedge clk);
        end
    endtask

    task automatic send_random(int gap);
        begin
            send_beat(pick_component(), pick_component(), pick_component(),
                      pick_component(), pick_component(), pick_component(),
                      pick_component(), 1'($urandom_range(0, 1)), gap);
        end
    endtask

    // Extremes, both rotation directions and the zero quaternion.
    task automatic test_directed();
        logic signed [CB-1:0] mn, mx;
        begin
            mn = {1'b1, {(CB-1){1'b0}}};
            mx = {1'b0, {(CB-1){1'b1}}};
            send_beat(0, 0, 0, 0, mx, mn, 5, 1'b0, 0);
            send_beat(0, 0, 0, 0, 1, 2, 3, 1'b1, 0);
            send_beat(1, 0, 0, 0, mx, mn, -1, 1'b0, 0);
            send_beat(mn, 0, 0, 0, mn, mn, mn, 1'b1, 0);
            send_beat(0, mn, 0, 0, mx, mx, mx, 1'b0, 0);
            send_beat(0, 0, mn, 0, mn, mx, mn, 1'b1, 0);
            send_beat(0, 0, 0, mn, mx, mn, mx, 1'b0, 0);
            send_beat(mn, mn, mn, mn, mx, mx, mn, 1'b0, 0);
            send_beat(mn, mn, mn, mn, mx, mx, mn, 1'b1, 0);
            send_beat(mx, mx, mx, mx, mn, mn, mn, 1'b0, 0);
            send_beat(mx, mn, mx, mn, mn, mx, mx, 1'b1, 0);
            send_beat(1, 1, 0, 0, 1, 0, 0, 1'b0, 0);
            send_beat(1, 1, 1, 1, 1, 1, 1, 1'b1, 0);
            send_beat(1, 0, 0, 1, 1, 0, 0, 1'b0, 0);
            send_beat(1, 0, 0, 1, 1, 0, 0, 1'b1, 0);
            send_beat(3, 1, 0, 0, 0, 1, 0, 1'b0, 0);
            send_beat(-1, 2, -3, 4, 7, -7, 1, 1'b1, 0);
            send_beat(12345, -23456, 345, -4567, -32000, 31000, -1, 1'b0, 0);
            send_beat(0, 0, 0, 0, 0, 0, 0, 1'b0, 0);
            send_beat(0, -1, 0, 0, -1, -1, -1, 1'b1, 0);
        end
    endtask

    // Random beats with random gaps and back-to-back bursts.
    task automatic test_random_stream();
        int i;
        begin
            for (i = 0; i < 1150; i++)
            begin
                if ((i / 200) % 2 == 1)
                    send_random(0);
                else
                    send_random(pick_gap());
            end
            in_valid <= 1'b0;
        end
    endtask

    // Receiver stall pattern: mostly ready, with random single and repeated stalls.
    always @(posedge clk)
    begin
        if (stall_enable && $urandom_range(0, 99) < 30)
            rot_stall <= ($urandom_range(0, 9) == 0) ? ($urandom_range(0, 1) == 1)
                                                     : 1'b1;
        else
            rot_stall <= 1'b0;
    end

    // Compare each accepted result beat with the oldest expectation.
    always @(posedge clk)
    begin
        rotation_t exp_rot;
        if (rst_n && rot_valid && !rot_stall)
        begin
            if (expected_rotations.size() == 0)
            begin
                orphan_count++;
                if (mismatch_count + orphan_count <= 10)
                    $display("unexpected result beat x=%0d y=%0d z=%0d err=%0b",
                             rotated_x, rotated_y, rotated_z, zero_quat_error);
            end
            else
            begin
                exp_rot = expected_rotations.pop_front();
                if (rotated_x !== exp_rot.rx || rotated_y !== exp_rot.ry ||
                    rotated_z !== exp_rot.rz || zero_quat_error !== exp_rot.err)
                begin
                    mismatch_count++;
                    if (mismatch_count + orphan_count <= 10)
                        $display("mismatch exp %0d %0d %0d err=%0b got %0d %0d %0d err=%0b",
                                 exp_rot.rx, exp_rot.ry, exp_rot.rz, exp_rot.err,
                                 rotated_x, rotated_y, rotated_z, zero_quat_error);
                end
            end
        end
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #5_000_000;
        $display("quaternion_vector_rotate_core regression: fail");
        $finish;
    end

    initial
    begin
        int wait_cycles;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        test_directed();
        test_random_stream();
        wait_cycles = 0;
        while (expected_rotations.size() != 0 && wait_cycles < 20000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (LATENCY + 5) @(posedge clk);
        if (mismatch_count == 0 && orphan_count == 0 && expected_rotations.size() == 0)
            $display("quaternion_vector_rotate_core regression: pass");
        else
            $display("quaternion_vector_rotate_core regression: fail");
        $finish;
    end

endmodule
